// ===== rtl/core/voice_mixer_alaw_encoder_defines.svh =====
// Assertion macros shared by the mixer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef VOICE_MIXER_ALAW_ENCODER_DEFINES_SVH
`define VOICE_MIXER_ALAW_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define VMAE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vmae assertion failed");
`define VMAE_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("vmae forbidden condition seen");
`else
`define VMAE_ASSERT(lbl, clk, rst_n, prop)
`define VMAE_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/vmae_pkg.sv =====
// Types, constants and the A-law encoder function for the voice mixer.
// No dependencies.
package vmae_pkg;

    localparam int MAX_VOICES = 8;

    localparam logic [7:0] ALAW_POS_MASK = 8'hD5;
    localparam logic [7:0] ALAW_NEG_MASK = 8'h55;

    typedef enum logic [2:0] {
        CMD_MIX    = 3'd0,
        CMD_VSTART = 3'd1,
        CMD_VSTOP  = 3'd2,
        CMD_VVOL   = 3'd3,
        CMD_MSTART = 3'd4,
        CMD_MQUEUE = 3'd5,
        CMD_MSTOP  = 3'd6,
        CMD_NOP    = 3'd7
    } t_cmd;

    // classified command as it travels from front to back
    typedef struct packed {
        t_cmd               cmd;
        logic               ch_ok;
        logic               zero_len;
        logic [2:0]         ch;
        logic [15:0]        vlen;
        logic [11:0]        mlen;
        logic [6:0]         vol;
        logic [63:0]        samples;
        logic signed [15:0] music;
    } t_op;

    // A-law byte of a 12-bit offset-binary code
    function automatic logic [7:0] alaw_encode(input logic [11:0] lin);
        logic [11:0] mag;
        logic [11:0] sh;
        logic [7:0]  mask;
        logic [2:0]  seg;
        logic [3:0]  bits;
        if (lin[11]) begin
            mag  = {lin[10:0], 1'b0};
            mask = ALAW_POS_MASK;
        end else begin
            // 2*(2048-c)-1 == 4095-2c
            mag  = ~{lin[10:0], 1'b0};
            mask = ALAW_NEG_MASK;
        end
        seg = 3'd7;
        for (int s = 6; s >= 0; s--) begin
            if (mag < (12'd32 << s)) begin
                seg = 3'(s);
            end
        end
        sh   = mag >> seg;
        bits = (seg < 3'd2) ? mag[4:1] : sh[3:0];
        return {1'b0, seg, bits} ^ mask;
    endfunction

endpackage

// ===== rtl/core/vmae_if.sv =====
// Valid/ready channel interfaces for the mixer command and result words.
// No dependencies.
interface vmae_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic [2:0]         voice_channel;
    logic [15:0]        length;
    logic [6:0]         volume;
    logic [63:0]        voice_samples;
    logic signed [15:0] music_sample;

    modport source (output valid, cmd, voice_channel, length, volume, voice_samples,
                    music_sample, input ready);
    modport sink   (input valid, cmd, voice_channel, length, volume, voice_samples,
                    music_sample, output ready);
endinterface

interface vmae_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  alaw_code;
    logic [11:0] linear_code;
    logic        silent;
    logic [7:0]  voices_active;
    logic        music_active;
    logic        music_bank;
    logic        music_switched;
    logic        status;

    modport source (output valid, alaw_code, linear_code, silent, voices_active,
                    music_active, music_bank, music_switched, status, input ready);
    modport sink   (input valid, alaw_code, linear_code, silent, voices_active,
                    music_active, music_bank, music_switched, status, output ready);
endinterface

// ===== rtl/core/vmae_front.sv =====
// Command front end: decodes and classifies each incoming word.
// Depends on vmae_pkg and vmae_req_if.
module vmae_front #(
    parameter int NUM_VOICES       = 8,
    parameter int MUSIC_BUFFER_LEN = 2048
) (
    vmae_req_if.sink        i_req,
    input  logic            i_op_ready,
    output logic            o_op_valid,
    output vmae_pkg::t_op   o_op
);

    localparam logic [11:0] BUF_LEN = 12'(MUSIC_BUFFER_LEN);

    logic [11:0] clamped;

    always_comb begin
        clamped = (i_req.length > 16'(MUSIC_BUFFER_LEN)) ? BUF_LEN : i_req.length[11:0];

        o_op.cmd      = vmae_pkg::t_cmd'(i_req.cmd);
        o_op.ch_ok    = ({1'b0, i_req.voice_channel} < 4'(NUM_VOICES));
        o_op.zero_len = (i_req.length == 16'd0);
        o_op.ch       = i_req.voice_channel;
        o_op.vlen     = i_req.length;
        o_op.vol      = i_req.volume;
        o_op.samples  = i_req.voice_samples;
        o_op.music    = i_req.music_sample;
        // music start with zero length plays a full buffer; queue keeps zero
        if (o_op.cmd == vmae_pkg::CMD_MSTART && o_op.zero_len) begin
            o_op.mlen = BUF_LEN;
        end else begin
            o_op.mlen = clamped;
        end
    end

    assign o_op_valid  = i_req.valid;
    assign i_req.ready = i_op_ready;

endmodule

// ===== rtl/core/vmae_queue.sv =====
// Two-entry queue of classified commands between front and back.
// Depends on vmae_pkg and the assertion macro header.
`include "voice_mixer_alaw_encoder_defines.svh"
module vmae_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vmae_pkg::t_op  i_data,
    output logic           o_full,
    output logic           o_valid,
    output vmae_pkg::t_op  o_data,
    input  logic           i_pop
);

    vmae_pkg::t_op r_mem [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_cnt;
    logic          push_ok;

    assign push_ok = i_push && !o_full;
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({push_ok, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `VMAE_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= 2'd2)
    `VMAE_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && r_cnt == 2'd0)
    `VMAE_ASSERT(a_push_count, i_clk, i_rst_n, push_ok && !i_pop |=> r_cnt == $past(r_cnt) + 2'd1)

endmodule

// ===== rtl/core/vmae_back.sv =====
// Execution back end: voice/music state, product lanes, sum and A-law stages.
// Depends on vmae_pkg, vmae_rsp_if and the assertion macro header.
`include "voice_mixer_alaw_encoder_defines.svh"
module vmae_back #(
    parameter int NUM_VOICES       = 8,
    parameter int MUSIC_BUFFER_LEN = 2048
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_op_valid,
    input  vmae_pkg::t_op  i_op,
    output logic           o_op_pop,
    vmae_rsp_if.source     o_rsp
);

    localparam int          NV      = vmae_pkg::MAX_VOICES;
    localparam logic [11:0] BUF_LEN = 12'(MUSIC_BUFFER_LEN);

    typedef struct packed {
        logic       sound;
        logic       silent;
        logic [7:0] voices_active;
        logic       music_active;
        logic       music_bank;
        logic       music_switched;
        logic       status;
    } t_flags;

    // architectural state
    logic [15:0] r_vrem [NUM_VOICES];
    logic [6:0]  r_vlvl [NUM_VOICES];
    logic [11:0] r_mrem, r_mpend;
    logic        r_mplay, r_mbuf;
    logic [15:0] n_vrem [NUM_VOICES];
    logic [6:0]  n_vlvl [NUM_VOICES];
    logic [11:0] n_mrem, n_mpend;
    logic        n_mplay, n_mbuf;

    // stage 1: products, stage 2: linear code, output register
    logic                r1_v, r2_v, r_ov;
    logic signed [14:0]  r1_prod [NV];
    logic signed [15:0]  r1_mus;
    t_flags              r1_flags, r2_flags, r_out_flags;
    logic [11:0]         r2_lin, r_out_lin;
    logic [7:0]          r_out_alaw;

    logic signed [14:0]  n_prod [NV];
    logic signed [15:0]  full_prod [NV];
    logic signed [15:0]  n_mus;
    logic signed [19:0]  sum;
    logic [11:0]         mdec;
    logic [NV-1:0]       vact;
    t_flags              n_flags;
    logic                en;
    logic                pop;
    logic                out_zero;
    logic                out_switch;

    assign en       = !r_ov || o_rsp.ready;
    assign pop      = i_op_valid && en;
    assign o_op_pop = pop;

    always_comb begin
        n_vrem  = r_vrem;
        n_vlvl  = r_vlvl;
        n_mrem  = r_mrem;
        n_mpend = r_mpend;
        n_mplay = r_mplay;
        n_mbuf  = r_mbuf;
        n_mus   = '0;
        n_flags = '0;
        mdec    = '0;
        vact    = '0;
        for (int k = 0; k < NV; k++) begin
            n_prod[k]    = '0;
            full_prod[k] = '0;
        end
        for (int k = 0; k < NUM_VOICES; k++) begin
            vact[k] = (r_vrem[k] != 16'd0);
        end

        case (i_op.cmd)
            vmae_pkg::CMD_MIX: begin
                if (vact == '0 && !r_mplay) begin
                    n_flags.silent = 1'b1;
                end else begin
                    n_flags.sound = 1'b1;
                    for (int k = 0; k < NUM_VOICES; k++) begin
                        if (vact[k]) begin
                            full_prod[k] = $signed(i_op.samples[8*k +: 8])
                                           * $signed({1'b0, r_vlvl[k]});
                            n_prod[k]    = full_prod[k][14:0];
                            n_vrem[k]    = r_vrem[k] - 16'd1;
                        end
                    end
                    if (r_mplay) begin
                        n_mus = i_op.music;
                        mdec  = (r_mrem != 12'd0) ? r_mrem - 12'd1 : r_mrem;
                        if (mdec == 12'd0) begin
                            n_mbuf  = ~r_mbuf;
                            n_mrem  = (r_mpend != 12'd0) ? r_mpend : BUF_LEN;
                            n_mpend = 12'd0;
                            n_flags.music_switched = 1'b1;
                        end else begin
                            n_mrem = mdec;
                        end
                    end
                end
            end
            vmae_pkg::CMD_VSTART: begin
                n_flags.status = i_op.ch_ok && i_op.zero_len;
                for (int k = 0; k < NUM_VOICES; k++) begin
                    if (i_op.ch_ok && !i_op.zero_len && i_op.ch == 3'(k)) begin
                        n_vrem[k] = i_op.vlen;
                        n_vlvl[k] = i_op.vol;
                    end
                end
            end
            vmae_pkg::CMD_VSTOP: begin
                for (int k = 0; k < NUM_VOICES; k++) begin
                    if (i_op.ch_ok && i_op.ch == 3'(k)) begin
                        n_vrem[k] = 16'd0;
                    end
                end
            end
            vmae_pkg::CMD_VVOL: begin
                for (int k = 0; k < NUM_VOICES; k++) begin
                    if (i_op.ch_ok && i_op.ch == 3'(k)) begin
                        n_vlvl[k] = i_op.vol;
                    end
                end
            end
            vmae_pkg::CMD_MSTART: begin
                n_mbuf  = 1'b0;
                n_mrem  = i_op.mlen;
                n_mplay = 1'b1;
            end
            vmae_pkg::CMD_MQUEUE: begin
                n_mpend = i_op.mlen;
            end
            vmae_pkg::CMD_MSTOP: begin
                n_mplay = 1'b0;
                n_mrem  = 12'd0;
            end
            default: begin
            end
        endcase

        for (int k = 0; k < NUM_VOICES; k++) begin
            n_flags.voices_active[k] = (n_vrem[k] != 16'd0);
        end
        n_flags.music_active = n_mplay;
        n_flags.music_bank   = n_mbuf;
    end

    // nine-term sum; (floor(sum/16)+2048) mod 4096 is bits 15:4 with the top flipped
    always_comb begin
        sum = 20'(r1_mus);
        for (int k = 0; k < NV; k++) begin
            sum = sum + 20'(r1_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_VOICES; k++) begin
                r_vrem[k] <= '0;
                r_vlvl[k] <= '0;
            end
            r_mrem  <= '0;
            r_mpend <= '0;
            r_mplay <= 1'b0;
            r_mbuf  <= 1'b0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (pop) begin
                r_vrem  <= n_vrem;
                r_vlvl  <= n_vlvl;
                r_mrem  <= n_mrem;
                r_mpend <= n_mpend;
                r_mplay <= n_mplay;
                r_mbuf  <= n_mbuf;
            end
            if (en) begin
                r1_v <= i_op_valid;
                r2_v <= r1_v;
                r_ov <= r2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_prod     <= n_prod;
            r1_mus      <= n_mus;
            r1_flags    <= n_flags;
            r2_flags    <= r1_flags;
            r2_lin      <= r1_flags.sound ? {~sum[15], sum[14:4]} : 12'd0;
            r_out_flags <= r2_flags;
            r_out_lin   <= r2_lin;
            r_out_alaw  <= r2_flags.sound ? vmae_pkg::alaw_encode(r2_lin) : 8'd0;
        end
    end

    assign o_rsp.valid          = r_ov;
    assign o_rsp.alaw_code      = r_out_alaw;
    assign o_rsp.linear_code    = r_out_lin;
    assign o_rsp.silent         = r_out_flags.silent;
    assign o_rsp.voices_active  = r_out_flags.voices_active;
    assign o_rsp.music_active   = r_out_flags.music_active;
    assign o_rsp.music_bank     = r_out_flags.music_bank;
    assign o_rsp.music_switched = r_out_flags.music_switched;
    assign o_rsp.status         = r_out_flags.status;

    assign out_zero   = (r_out_alaw == 8'h00) && (r_out_lin == 12'h000);
    assign out_switch = r_ov && r_out_flags.music_switched;

    `VMAE_ASSERT(a_silent_zero, i_clk, i_rst_n, r_ov && r_out_flags.silent |-> out_zero)
    `VMAE_ASSERT(a_switch_plays, i_clk, i_rst_n, out_switch |-> r_out_flags.music_active)
    `VMAE_ASSERT(a_pop_enters, i_clk, i_rst_n, pop |=> r1_v)

endmodule

// ===== rtl/core/voice_mixer_alaw_encoder.sv =====
// Top level of the eight-voice plus music mixer with A-law output.
// Depends on vmae_pkg, vmae_if, vmae_front, vmae_queue and vmae_back.
//
// One command word in, one result word out. A mix command sums every playing
// voice (signed byte sample times 7-bit level) and, while music plays, the
// music sample, takes the sum /16 floored, biases it to a 12-bit code in
// offset binary (wrapping, no clipping) and A-law encodes it; the other
// commands start, stop or re-level a voice, or start, queue or stop music.
// While the result sink takes results, throughput is one word per clock: the
// back end updates all voice and music counters for one command per cycle and
// the front end decodes one word per cycle into a two-entry queue. A popped
// command goes into the execute register, then the sum register, then the
// output register holding the A-law byte. The back stages advance together
// whenever the output register is empty or being taken, so a stalled result
// sink backs up into the queue and then the input ready.
module voice_mixer_alaw_encoder #(
    parameter int NUM_VOICES       = 8,
    parameter int MUSIC_BUFFER_LEN = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vmae_req_if.sink    i_req,
    vmae_rsp_if.source  o_rsp
);

    // front -> queue
    vmae_pkg::t_op front_op;
    logic          front_valid;
    logic          q_full;

    // queue -> back
    vmae_pkg::t_op q_op;
    logic          q_valid;
    logic          q_pop;

    vmae_front #(
        .NUM_VOICES       (NUM_VOICES),
        .MUSIC_BUFFER_LEN (MUSIC_BUFFER_LEN)
    ) u_front (
        .i_req      (i_req),
        .i_op_ready (!q_full),
        .o_op_valid (front_valid),
        .o_op       (front_op)
    );

    // decouples decode from execute so either side can stall alone
    vmae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_op),
        .i_pop   (q_pop)
    );

    vmae_back #(
        .NUM_VOICES       (NUM_VOICES),
        .MUSIC_BUFFER_LEN (MUSIC_BUFFER_LEN)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_valid),
        .i_op       (q_op),
        .o_op_pop   (q_pop),
        .o_rsp      (o_rsp)
    );

endmodule
